>>> rtl/rational_accumulator_alu_macros.svh
// assertion helpers
`ifndef RATIONAL_ACCUMULATOR_ALU_MACROS_SVH
`define RATIONAL_ACCUMULATOR_ALU_MACROS_SVH

// same-cycle implication
`define RAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rat_alu assertion failed");

// next-cycle implication
`define RAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rat_alu assertion failed");

`endif

>>> rtl/rat_alu_pkg.sv
package rat_alu_pkg;

   localparam logic [2:0] KIND_LOAD     = 3'd0;
   localparam logic [2:0] KIND_ADD      = 3'd1;
   localparam logic [2:0] KIND_SUBTRACT = 3'd2;
   localparam logic [2:0] KIND_MULTIPLY = 3'd3;
   localparam logic [2:0] KIND_DIVIDE   = 3'd4;
   localparam logic [2:0] KIND_REDUCE   = 3'd5;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_MUL_LOAD,
      DP_MUL_STEP,
      DP_MUL_STORE,
      DP_GCD_STEP,
      DP_DIV_LOAD,
      DP_DIV_STEP,
      DP_DIV_STORE,
      DP_COMMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] prod_idx;
      logic       div_den;
   } dp_cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic gcd_big;
   } dp_status_type;

endpackage

>>> rtl/rat_alu_dp.sv
module rat_alu_dp #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rat_alu_pkg::dp_cmd_type   cmd,
   output rat_alu_pkg::dp_status_type status,
   input  logic [2:0]                req_kind,
   input  logic signed [31:0]        req_operand_num,
   input  logic signed [31:0]        req_operand_den,
   output logic signed [31:0]        rsp_result_num,
   output logic signed [31:0]        rsp_result_den,
   output logic                      rsp_overflow,
   output logic                      rsp_zero_den
);

   localparam int KW = $clog2(WIDTH);

   function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
      return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
   endfunction

   logic signed [WIDTH-1:0] acc_num_ff, acc_den_ff;
   logic signed [WIDTH-1:0] on_ff, od_ff;
   logic [2:0]              kind_ff;
   logic                    ovf_ff;
   logic [WIDTH-1:0]        p_ff [3];
   logic [WIDTH-1:0]        ma_ff;
   logic [2*WIDTH-1:0]      prod_ff;
   logic                    neg_ff;
   logic [WIDTH-1:0]        ga_ff, gb_ff, g_ff;
   logic [KW-1:0]           gk_ff;
   logic                    gdone_ff;
   logic [WIDTH-1:0]        rem_ff, quo_ff;
   logic                    dneg_ff;
   logic signed [31:0]      rsp_num_ff, rsp_den_ff;
   logic                    rsp_ovf_ff, rsp_zero_ff;

   logic signed [WIDTH-1:0] on_w, od_w;
   logic                    opw;
   logic [WIDTH-1:0]        mul_a, mul_b;
   logic [WIDTH:0]          upper;
   logic [2*WIDTH:0]        shifted;
   logic [2*WIDTH-1:0]      full;
   logic                    mul_ovf;
   logic [WIDTH:0]          div_sh, div_diff;
   logic [WIDTH-1:0]        div_src, quo_signed;
   logic [WIDTH-1:0]        t2;
   logic [WIDTH:0]          sum;
   logic                    add_ovf;
   logic signed [WIDTH-1:0] new_n, new_d;

   assign on_w = WIDTH'(req_operand_num);
   assign od_w = WIDTH'(req_operand_den);
   assign opw  = (32'(on_w) != req_operand_num) || (32'(od_w) != req_operand_den);

   always_comb begin
      case (cmd.prod_idx)
         2'd0: begin
            mul_a = acc_num_ff;
            mul_b = (kind_ff == rat_alu_pkg::KIND_MULTIPLY) ? on_ff : od_ff;
         end
         2'd1: begin
            mul_a = acc_den_ff;
            mul_b = (kind_ff == rat_alu_pkg::KIND_MULTIPLY) ? od_ff : on_ff;
         end
         default: begin
            mul_a = acc_den_ff;
            mul_b = od_ff;
         end
      endcase
   end

   assign upper   = {1'b0, prod_ff[2*WIDTH-1:WIDTH]} + (prod_ff[0] ? {1'b0, ma_ff} : '0);
   assign shifted = {upper, prod_ff[WIDTH-1:0]};
   assign full    = neg_ff ? (~prod_ff + (2*WIDTH)'(1)) : prod_ff;
   assign mul_ovf = !((&full[2*WIDTH-1:WIDTH-1]) || !(|full[2*WIDTH-1:WIDTH-1]));

   assign div_src    = cmd.div_den ? acc_den_ff : acc_num_ff;
   assign div_sh     = {rem_ff, quo_ff[WIDTH-1]};
   assign div_diff   = div_sh - {1'b0, g_ff};
   assign quo_signed = dneg_ff ? (~quo_ff + WIDTH'(1)) : quo_ff;

   always_comb begin
      t2      = (kind_ff == rat_alu_pkg::KIND_SUBTRACT) ? (~p_ff[1] + WIDTH'(1)) : p_ff[1];
      sum     = {p_ff[0][WIDTH-1], p_ff[0]} + {t2[WIDTH-1], t2};
      add_ovf = 1'b0;
      new_n   = acc_num_ff;
      new_d   = acc_den_ff;
      case (kind_ff)
         rat_alu_pkg::KIND_LOAD: begin
            new_n = on_ff;
            new_d = od_ff;
         end
         rat_alu_pkg::KIND_ADD, rat_alu_pkg::KIND_SUBTRACT: begin
            add_ovf = (sum[WIDTH] ^ sum[WIDTH-1]) ||
                      ((kind_ff == rat_alu_pkg::KIND_SUBTRACT) &&
                       (p_ff[1] == {1'b1, {(WIDTH-1){1'b0}}}));
            new_n = sum[WIDTH-1:0];
            new_d = p_ff[2];
         end
         rat_alu_pkg::KIND_MULTIPLY, rat_alu_pkg::KIND_DIVIDE: begin
            new_n = p_ff[0];
            new_d = p_ff[1];
         end
         default: begin
            new_n = acc_num_ff;
            new_d = acc_den_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_num_ff <= WIDTH'(1);
         acc_den_ff <= WIDTH'(1);
         gdone_ff   <= 1'b0;
      end else begin
         case (cmd.op)
            rat_alu_pkg::DP_CAPTURE: begin
               on_ff    <= on_w;
               od_ff    <= od_w;
               kind_ff  <= req_kind;
               ovf_ff   <= opw && (req_kind <= rat_alu_pkg::KIND_DIVIDE);
               ga_ff    <= mag_of(acc_num_ff);
               gb_ff    <= mag_of(acc_den_ff);
               gk_ff    <= '0;
               gdone_ff <= 1'b0;
            end
            rat_alu_pkg::DP_MUL_LOAD: begin
               ma_ff   <= mag_of(mul_a);
               prod_ff <= {{WIDTH{1'b0}}, mag_of(mul_b)};
               neg_ff  <= mul_a[WIDTH-1] ^ mul_b[WIDTH-1];
            end
            rat_alu_pkg::DP_MUL_STEP: begin
               prod_ff <= shifted[2*WIDTH:1];
            end
            rat_alu_pkg::DP_MUL_STORE: begin
               p_ff[cmd.prod_idx] <= full[WIDTH-1:0];
               ovf_ff             <= ovf_ff | mul_ovf;
            end
            rat_alu_pkg::DP_GCD_STEP: begin
               if (ga_ff == '0) begin
                  g_ff     <= gb_ff << gk_ff;
                  gdone_ff <= 1'b1;
               end else if (gb_ff == '0) begin
                  g_ff     <= ga_ff << gk_ff;
                  gdone_ff <= 1'b1;
               end else if (!ga_ff[0] && !gb_ff[0]) begin
                  ga_ff <= ga_ff >> 1;
                  gb_ff <= gb_ff >> 1;
                  gk_ff <= gk_ff + KW'(1);
               end else if (!ga_ff[0]) begin
                  ga_ff <= ga_ff >> 1;
               end else if (!gb_ff[0]) begin
                  gb_ff <= gb_ff >> 1;
               end else if (ga_ff >= gb_ff) begin
                  ga_ff <= (ga_ff - gb_ff) >> 1;
               end else begin
                  gb_ff <= (gb_ff - ga_ff) >> 1;
               end
            end
            rat_alu_pkg::DP_DIV_LOAD: begin
               quo_ff  <= mag_of(div_src);
               rem_ff  <= '0;
               dneg_ff <= div_src[WIDTH-1];
            end
            rat_alu_pkg::DP_DIV_STEP: begin
               if (!div_diff[WIDTH]) begin
                  rem_ff <= div_diff[WIDTH-1:0];
                  quo_ff <= {quo_ff[WIDTH-2:0], 1'b1};
               end else begin
                  rem_ff <= div_sh[WIDTH-1:0];
                  quo_ff <= {quo_ff[WIDTH-2:0], 1'b0};
               end
            end
            rat_alu_pkg::DP_DIV_STORE: begin
               if (cmd.div_den) begin
                  acc_den_ff <= quo_signed;
               end else begin
                  acc_num_ff <= quo_signed;
               end
            end
            rat_alu_pkg::DP_COMMIT: begin
               acc_num_ff  <= new_n;
               acc_den_ff  <= new_d;
               rsp_num_ff  <= 32'(new_n);
               rsp_den_ff  <= 32'(new_d);
               rsp_ovf_ff  <= ovf_ff | add_ovf;
               rsp_zero_ff <= (new_d == '0);
            end
            default: begin
            end
         endcase
      end
   end

   assign status.gcd_done = gdone_ff;
   assign status.gcd_big  = |g_ff[WIDTH-1:1];

   assign rsp_result_num = rsp_num_ff;
   assign rsp_result_den = rsp_den_ff;
   assign rsp_overflow   = rsp_ovf_ff;
   assign rsp_zero_den   = rsp_zero_ff;

endmodule

>>> rtl/rat_alu_ctrl.sv
`include "rational_accumulator_alu_macros.svh"

module rat_alu_ctrl #(
   parameter int WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [2:0]                 req_kind,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rat_alu_pkg::dp_cmd_type    cmd,
   input  rat_alu_pkg::dp_status_type status
);

   localparam int CW = $clog2(WIDTH);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_MLOAD  = 9'b000000010,
      S_MSTEP  = 9'b000000100,
      S_MSTORE = 9'b000001000,
      S_GCD    = 9'b000010000,
      S_DLOAD  = 9'b000100000,
      S_DSTEP  = 9'b001000000,
      S_DSTORE = 9'b010000000,
      S_COMMIT = 9'b100000000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    idx_ff, idx_in;
   logic [1:0]    last_ff, last_in;
   logic          den_ff, den_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          step_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_last = (cnt_ff == CW'(WIDTH - 1));
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      den_in       = den_ff;
      cmd.op       = rat_alu_pkg::DP_NOP;
      cmd.prod_idx = idx_ff;
      cmd.div_den  = den_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op  = rat_alu_pkg::DP_CAPTURE;
               idx_in  = 2'd0;
               last_in = ((req_kind == rat_alu_pkg::KIND_ADD) ||
                          (req_kind == rat_alu_pkg::KIND_SUBTRACT)) ? 2'd2 : 2'd1;
               case (req_kind)
                  rat_alu_pkg::KIND_ADD, rat_alu_pkg::KIND_SUBTRACT,
                  rat_alu_pkg::KIND_MULTIPLY, rat_alu_pkg::KIND_DIVIDE: begin
                     state_in = S_MLOAD;
                  end
                  rat_alu_pkg::KIND_REDUCE: begin
                     state_in = S_GCD;
                  end
                  default: begin
                     state_in = S_COMMIT;
                  end
               endcase
            end
         end
         S_MLOAD: begin
            cmd.op   = rat_alu_pkg::DP_MUL_LOAD;
            cnt_in   = '0;
            state_in = S_MSTEP;
         end
         S_MSTEP: begin
            cmd.op = rat_alu_pkg::DP_MUL_STEP;
            cnt_in = cnt_ff + CW'(1);
            if (step_last) begin
               state_in = S_MSTORE;
            end
         end
         S_MSTORE: begin
            cmd.op = rat_alu_pkg::DP_MUL_STORE;
            if (idx_ff == last_ff) begin
               state_in = S_COMMIT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = S_MLOAD;
            end
         end
         S_GCD: begin
            if (status.gcd_done) begin
               den_in   = 1'b0;
               state_in = status.gcd_big ? S_DLOAD : S_COMMIT;
            end else begin
               cmd.op = rat_alu_pkg::DP_GCD_STEP;
            end
         end
         S_DLOAD: begin
            cmd.op   = rat_alu_pkg::DP_DIV_LOAD;
            cnt_in   = '0;
            state_in = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.op = rat_alu_pkg::DP_DIV_STEP;
            cnt_in = cnt_ff + CW'(1);
            if (step_last) begin
               state_in = S_DSTORE;
            end
         end
         S_DSTORE: begin
            cmd.op = rat_alu_pkg::DP_DIV_STORE;
            if (den_ff) begin
               state_in = S_COMMIT;
            end else begin
               den_in   = 1'b1;
               state_in = S_DLOAD;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.op   = rat_alu_pkg::DP_COMMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.op == rat_alu_pkg::DP_COMMIT) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         last_ff      <= '0;
         den_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         den_ff       <= den_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RAT_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall, state_ff != S_IDLE)
   `RAT_ASSERT_NEXT(a_commit_shows_item, clock, reset, cmd.op == rat_alu_pkg::DP_COMMIT, rsp_valid_ff)
   `RAT_ASSERT_NEXT(a_den_div_ends, clock, reset, state_ff == S_DSTORE && den_ff, state_ff == S_COMMIT)
   `RAT_ASSERT_IMPL(a_idx_in_range, clock, reset, state_ff == S_MSTORE, idx_ff <= last_ff && last_ff != 2'd0)

endmodule

>>> rtl/rational_accumulator_alu.sv
// one item at a time; shared bit-serial multiplier plus bit-serial divider, one bit a cycle
// load or unused kind: no arithmetic, straight from capture to commit
// multiply/divide: two products, add/subtract: three, each loaded, shifted and stored
// reduce: binary gcd, then two divisions by it when the gcd is above 1
// next item accepted once the result sits in the output register
// synchronous reset sets the accumulator to 1/1 and clears the output valid
module rational_accumulator_alu #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_kind,
   input  logic signed [31:0] req_operand_num,
   input  logic signed [31:0] req_operand_den,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_num,
   output logic signed [31:0] rsp_result_den,
   output logic               rsp_overflow,
   output logic               rsp_zero_den
);

   rat_alu_pkg::dp_cmd_type    cmd;
   rat_alu_pkg::dp_status_type status;

   rat_alu_ctrl #(.WIDTH(WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rat_alu_dp #(.WIDTH(WIDTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (req_kind),
      .req_operand_num (req_operand_num),
      .req_operand_den (req_operand_den),
      .rsp_result_num  (rsp_result_num),
      .rsp_result_den  (rsp_result_den),
      .rsp_overflow    (rsp_overflow),
      .rsp_zero_den    (rsp_zero_den)
   );

endmodule
